// ===== design/zmpp_pkg.sv =====
// ----------------------------------------------------------------------------
// Zone map page pruner package
// Shared types, constants and helpers for the page pruner.
// ----------------------------------------------------------------------------
package zmpp_pkg;

    localparam int ROW_INDEX_BITS = 40;
    localparam int OUT_ROW_BITS   = 40;
    localparam int CFG_IDX_BITS   = 3;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = 1;

    localparam logic [ROW_INDEX_BITS-1:0] ROW_MAX = {ROW_INDEX_BITS{1'b1}};

    localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER_ENABLED = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COLUMN_TYPE    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_ENABLED    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_ENABLED   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_BOUND      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_BOUND     = 3'd5;

    localparam logic [1:0] COL_INT32  = 2'd0;
    localparam logic [1:0] COL_INT64  = 2'd1;
    localparam logic [1:0] COL_DOUBLE = 2'd2;
    localparam logic [1:0] COL_OTHER  = 2'd3;

    typedef struct packed {
        logic [15:0] page_rows;
        logic        stats_present;
        logic [63:0] page_min;
        logic [63:0] page_max;
        logic        final_page;
    } t_page_req;

    typedef struct packed {
        logic [OUT_ROW_BITS-1:0] span_first;
        logic [OUT_ROW_BITS-1:0] span_after;
        logic                    last_range;
        logic                    no_range;
    } t_range_req;

    typedef struct packed {
        logic        filter_enabled;
        logic [1:0]  column_type;
        logic        low_enabled;
        logic        high_enabled;
        logic [63:0] low_bound;
        logic [63:0] high_bound;
    } t_cfg;

    typedef struct packed {
        logic [15:0] page_rows;
        logic        survives;
        logic        final_page;
    } t_class_req;

    function automatic logic [OUT_ROW_BITS-1:0] to_out(input logic [ROW_INDEX_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[OUT_ROW_BITS-1:0];
    endfunction

endpackage

// ===== design/zmpp_classify.sv =====
// ----------------------------------------------------------------------------
// Page classifier
// Registers each page's row count and final flag with its survival verdict.
// ----------------------------------------------------------------------------
module zmpp_classify (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  zmpp_pkg::t_cfg        i_cfg,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  zmpp_pkg::t_page_req   i_page,
    output logic                  o_valid,
    input  logic                  i_stall,
    output zmpp_pkg::t_class_req  o_req
);

    logic                 r_valid;
    zmpp_pkg::t_class_req r_req;
    logic                 w_surv;
    logic                 w_low_fail;
    logic                 w_high_fail;

    function automatic logic key_lt(input logic [63:0] a, input logic [63:0] b,
                                    input logic [1:0] ct);
        logic [63:0] ka;
        logic [63:0] kb;
        logic        an;
        logic        bn;
        logic        az;
        logic        r;
        ka = a;
        kb = b;
        r  = 1'b0;
        case (ct)
            zmpp_pkg::COL_INT32: begin
                ka = {32'd0, a[31] ^ 1'b1, a[30:0]};
                kb = {32'd0, b[31] ^ 1'b1, b[30:0]};
                r  = ka < kb;
            end
            zmpp_pkg::COL_INT64: begin
                ka = {a[63] ^ 1'b1, a[62:0]};
                kb = {b[63] ^ 1'b1, b[62:0]};
                r  = ka < kb;
            end
            zmpp_pkg::COL_DOUBLE: begin
                an = (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
                bn = (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
                az = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
                if (an || bn || az) begin
                    r = 1'b0;
                end else if (a[63] != b[63]) begin
                    r = a[63];
                end else if (a[63]) begin
                    r = a[62:0] > b[62:0];
                end else begin
                    r = a[62:0] < b[62:0];
                end
            end
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    assign w_low_fail  = i_cfg.low_enabled &&
                         key_lt(i_page.page_max, i_cfg.low_bound, i_cfg.column_type);
    assign w_high_fail = i_cfg.high_enabled &&
                         key_lt(i_cfg.high_bound, i_page.page_min, i_cfg.column_type);
    assign w_surv = !i_cfg.filter_enabled || (i_cfg.column_type == zmpp_pkg::COL_OTHER) ||
                    (i_page.stats_present && !w_low_fail && !w_high_fail);

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_req.page_rows  <= i_page.page_rows;
            r_req.survives   <= w_surv;
            r_req.final_page <= i_page.final_page;
        end
    end

endmodule

// ===== design/zmpp_queue.sv =====
// ----------------------------------------------------------------------------
// Classified page queue
// Two-entry queue between the classifier and the range builder.
// ----------------------------------------------------------------------------
module zmpp_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  zmpp_pkg::t_class_req  i_req,
    output logic                  o_valid,
    input  logic                  i_stall,
    output zmpp_pkg::t_class_req  o_req
);

    zmpp_pkg::t_class_req r_mem [zmpp_pkg::QUEUE_DEPTH];
    logic [zmpp_pkg::QUEUE_PTR_BITS-1:0] r_wr;
    logic [zmpp_pkg::QUEUE_PTR_BITS-1:0] r_rd;
    logic [zmpp_pkg::QUEUE_PTR_BITS:0]   r_cnt;
    logic w_push;
    logic w_pop;

    assign o_stall = (r_cnt == 2'(zmpp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_req   = r_mem[r_rd];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) begin
            r_mem[r_wr] <= i_req;
        end
    end

endmodule

// ===== design/zmpp_build.sv =====
// ----------------------------------------------------------------------------
// Range builder
// Advances the row cursor, merges surviving pages and emits row ranges.
// ----------------------------------------------------------------------------
module zmpp_build (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  zmpp_pkg::t_class_req  i_req,
    output logic                  o_valid,
    input  logic                  i_stall,
    output zmpp_pkg::t_range_req  o_range
);

    logic [zmpp_pkg::ROW_INDEX_BITS-1:0] r_cursor;
    logic [zmpp_pkg::ROW_INDEX_BITS-1:0] r_run_start;
    logic                                r_run_open;
    logic                                r_valid;
    zmpp_pkg::t_range_req                r_range;

    logic [zmpp_pkg::ROW_INDEX_BITS:0]   w_sum;
    logic [zmpp_pkg::ROW_INDEX_BITS-1:0] w_end;
    logic                                w_take;
    logic                                w_open;
    logic [zmpp_pkg::ROW_INDEX_BITS-1:0] w_rs;
    logic                                w_emit;
    zmpp_pkg::t_range_req                w_out;

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_range = r_range;
    assign w_take  = i_valid && !o_stall;

    always_comb begin
        w_sum  = {1'b0, r_cursor} + (zmpp_pkg::ROW_INDEX_BITS+1)'(i_req.page_rows);
        w_end  = w_sum[zmpp_pkg::ROW_INDEX_BITS] ? zmpp_pkg::ROW_MAX
                                                 : w_sum[zmpp_pkg::ROW_INDEX_BITS-1:0];
        w_open = r_run_open;
        w_rs   = r_run_start;
        w_emit = 1'b0;
        w_out  = '0;
        if (w_end != r_cursor) begin
            if (i_req.survives) begin
                if (!r_run_open) begin
                    w_open = 1'b1;
                    w_rs   = r_cursor;
                end
            end else if (r_run_open) begin
                w_emit = 1'b1;
                w_open = 1'b0;
                w_out.span_first = zmpp_pkg::to_out(r_run_start);
                w_out.span_after = zmpp_pkg::to_out(r_cursor);
                w_out.last_range = i_req.final_page;
            end
        end
        if (i_req.final_page) begin
            if (w_open) begin
                w_emit = 1'b1;
                w_out.span_first = zmpp_pkg::to_out(w_rs);
                w_out.span_after = zmpp_pkg::to_out(w_end);
                w_out.last_range = 1'b1;
                w_out.no_range   = 1'b0;
            end else if (!w_emit) begin
                w_emit = 1'b1;
                w_out.last_range = 1'b1;
                w_out.no_range   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_cursor    <= '0;
            r_run_open  <= 1'b0;
            r_run_start <= '0;
        end else if (!o_stall) begin
            r_valid <= w_take && w_emit;
            if (w_take) begin
                r_cursor    <= i_req.final_page ? '0 : w_end;
                r_run_open  <= i_req.final_page ? 1'b0 : w_open;
                r_run_start <= i_req.final_page ? '0 : w_rs;
            end
        end
        if (w_take && !o_stall) begin
            r_range <= w_out;
        end
    end

endmodule

// ===== design/zone_map_page_pruner_core.sv =====
// ----------------------------------------------------------------------------
// Zone map page pruner core
// Prunes column pages against min/max bounds and merges survivors into ranges.
// ----------------------------------------------------------------------------
// Usage: one page descriptor is a request on i_page_valid/o_page_stall; a row
// range request leaves on o_range_valid/i_range_stall. Configuration is
// written over i_cfg_valid/o_cfg_ready (always ready); the user must write it
// only while the block idles, which the block does not enforce. Throughput:
// one page per cycle unless the output stalls, set by the cursor add and
// merge step in the range builder. An accepted page passes the classifier
// register, the queue and the output register. A page causes zero or one
// range. Reset clears the cursor, the open run, the queue and all configuration
// registers. A stalled output holds its request; the builder then halts, the
// two-entry queue fills and the classifier stalls the input in turn.
// ----------------------------------------------------------------------------
module zone_map_page_pruner_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [zmpp_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [63:0]                         i_cfg_data,
    input  logic                                i_page_valid,
    output logic                                o_page_stall,
    input  zmpp_pkg::t_page_req                 i_page,
    output logic                                o_range_valid,
    input  logic                                i_range_stall,
    output zmpp_pkg::t_range_req                o_range
);

    zmpp_pkg::t_cfg       r_cfg;
    logic                 w_c_valid;
    logic                 w_c_stall;
    zmpp_pkg::t_class_req w_c_req;
    logic                 w_q_valid;
    logic                 w_q_stall;
    zmpp_pkg::t_class_req w_q_req;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                zmpp_pkg::CFG_FILTER_ENABLED: r_cfg.filter_enabled <= i_cfg_data[0];
                zmpp_pkg::CFG_COLUMN_TYPE:    r_cfg.column_type    <= i_cfg_data[1:0];
                zmpp_pkg::CFG_LOW_ENABLED:    r_cfg.low_enabled    <= i_cfg_data[0];
                zmpp_pkg::CFG_HIGH_ENABLED:   r_cfg.high_enabled   <= i_cfg_data[0];
                zmpp_pkg::CFG_LOW_BOUND:      r_cfg.low_bound      <= i_cfg_data;
                zmpp_pkg::CFG_HIGH_BOUND:     r_cfg.high_bound     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    zmpp_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_page_valid),
        .o_stall (o_page_stall),
        .i_page  (i_page),
        .o_valid (w_c_valid),
        .i_stall (w_c_stall),
        .o_req   (w_c_req)
    );

    zmpp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_c_valid),
        .o_stall (w_c_stall),
        .i_req   (w_c_req),
        .o_valid (w_q_valid),
        .i_stall (w_q_stall),
        .o_req   (w_q_req)
    );

    zmpp_build u_build (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_stall (w_q_stall),
        .i_req   (w_q_req),
        .o_valid (o_range_valid),
        .i_stall (i_range_stall),
        .o_range (o_range)
    );

endmodule

// ===== design/zmpp_checker.sv =====
// ----------------------------------------------------------------------------
// Zone map page pruner checker
// Port-level properties of the pruner core.
// ----------------------------------------------------------------------------
module zmpp_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_range_valid,
    input logic                 i_range_stall,
    input zmpp_pkg::t_range_req o_range
);

    a_marker_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_range_valid && o_range.no_range |->
            o_range.last_range && o_range.span_first == '0 && o_range.span_after == '0)
        else $error("empty marker malformed");

    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_range_valid && !o_range.no_range |-> o_range.span_first < o_range.span_after)
        else $error("range empty or reversed");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_range_valid && i_range_stall |=> o_range_valid && $stable(o_range))
        else $error("stalled range changed");

endmodule

bind zone_map_page_pruner_core zmpp_checker u_zmpp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_range_valid (o_range_valid),
    .i_range_stall (i_range_stall),
    .o_range       (o_range)
);

// ===== verif/tb_zone_map_page_pruner_core.sv =====
// ----------------------------------------------------------------------------
// Zone map page pruner core testbench
// Drives page descriptors through directed and random phases, predicts the
// merged row ranges in a behavioral model and checks every range request.
// ----------------------------------------------------------------------------
module tb_zone_map_page_pruner_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 12;

    typedef struct {
        zmpp_pkg::t_page_req  page;
        bit                   has_exp;
        zmpp_pkg::t_range_req exp_range;
    } t_dir_row;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [zmpp_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [63:0] cfg_data;
    logic       page_valid;
    logic       page_stall;
    zmpp_pkg::t_page_req  page;
    logic       range_valid;
    logic       range_stall;
    zmpp_pkg::t_range_req range_out;

    // predictor state
    zmpp_pkg::t_cfg                      cfg_shadow;
    logic [zmpp_pkg::ROW_INDEX_BITS-1:0] cursor;
    bit                                  run_open;
    logic [zmpp_pkg::ROW_INDEX_BITS-1:0] run_start;

    zmpp_pkg::t_range_req range_queue[$];
    t_dir_row   dir_rows[$];
    int         mismatches;
    int         ranges_seen;
    int         pages_sent;
    int         idle_cycles;
    int         send_idle_pct;
    int         recv_stall_pct;

    zone_map_page_pruner_core u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_page_valid (page_valid),
        .o_page_stall (page_stall),
        .i_page       (page),
        .o_range_valid(range_valid),
        .i_range_stall(range_stall),
        .o_range      (range_out)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit is_nan(logic [63:0] b);
        return b[62:52] == 11'h7ff && b[51:0] != 0;
    endfunction

    function automatic bit dbl_less(logic [63:0] a, logic [63:0] b);
        if (is_nan(a) || is_nan(b)) return 1'b0;
        return $bitstoreal(a) < $bitstoreal(b);
    endfunction

    function automatic bit page_survives(zmpp_pkg::t_page_req p);
        logic [63:0] lo_min, lo_max, lo_lb, lo_hb;
        if (!cfg_shadow.filter_enabled || cfg_shadow.column_type == zmpp_pkg::COL_OTHER)
            return 1'b1;
        if (!p.stats_present) return 1'b0;
        if (cfg_shadow.column_type == zmpp_pkg::COL_DOUBLE) begin
            if (cfg_shadow.low_enabled && dbl_less(p.page_max, cfg_shadow.low_bound))
                return 1'b0;
            if (cfg_shadow.high_enabled && dbl_less(cfg_shadow.high_bound, p.page_min))
                return 1'b0;
            return 1'b1;
        end
        if (cfg_shadow.column_type == zmpp_pkg::COL_INT32) begin
            lo_min = {32'b0, p.page_min[31:0] ^ 32'h8000_0000};
            lo_max = {32'b0, p.page_max[31:0] ^ 32'h8000_0000};
            lo_lb  = {32'b0, cfg_shadow.low_bound[31:0] ^ 32'h8000_0000};
            lo_hb  = {32'b0, cfg_shadow.high_bound[31:0] ^ 32'h8000_0000};
        end else begin
            lo_min = p.page_min ^ 64'h8000_0000_0000_0000;
            lo_max = p.page_max ^ 64'h8000_0000_0000_0000;
            lo_lb  = cfg_shadow.low_bound ^ 64'h8000_0000_0000_0000;
            lo_hb  = cfg_shadow.high_bound ^ 64'h8000_0000_0000_0000;
        end
        if (cfg_shadow.low_enabled && lo_max < lo_lb) return 1'b0;
        if (cfg_shadow.high_enabled && lo_min > lo_hb) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit predict_range(zmpp_pkg::t_page_req p,
                                         output zmpp_pkg::t_range_req r);
        logic [zmpp_pkg::ROW_INDEX_BITS:0]   sum;
        logic [zmpp_pkg::ROW_INDEX_BITS-1:0] first_row;
        bit                                  found;
        found = 1'b0;
        r = '0;
        first_row = cursor;
        sum = {1'b0, cursor} + p.page_rows;
        cursor = sum > zmpp_pkg::ROW_MAX ? zmpp_pkg::ROW_MAX
                                         : sum[zmpp_pkg::ROW_INDEX_BITS-1:0];
        if (cursor != first_row) begin
            if (page_survives(p)) begin
                if (!run_open) begin
                    run_open = 1'b1;
                    run_start = first_row;
                end
            end else if (run_open) begin
                r = '{run_start, first_row, p.final_page, 1'b0};
                run_open = 1'b0;
                found = 1'b1;
            end
        end
        if (p.final_page) begin
            if (run_open) begin
                r = '{run_start, cursor, 1'b1, 1'b0};
                found = 1'b1;
            end else if (!found) begin
                r = '{'0, '0, 1'b1, 1'b1};
                found = 1'b1;
            end
            cursor = '0;
            run_open = 1'b0;
            run_start = '0;
        end
        return found;
    endfunction

    task automatic write_reg(logic [zmpp_pkg::CFG_IDX_BITS-1:0] idx, logic [63:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        case (idx)
            zmpp_pkg::CFG_FILTER_ENABLED: cfg_shadow.filter_enabled = val[0];
            zmpp_pkg::CFG_COLUMN_TYPE:    cfg_shadow.column_type = val[1:0];
            zmpp_pkg::CFG_LOW_ENABLED:    cfg_shadow.low_enabled = val[0];
            zmpp_pkg::CFG_HIGH_ENABLED:   cfg_shadow.high_enabled = val[0];
            zmpp_pkg::CFG_LOW_BOUND:      cfg_shadow.low_bound = val;
            zmpp_pkg::CFG_HIGH_BOUND:     cfg_shadow.high_bound = val;
            default: ;
        endcase
    endtask

    task automatic write_all(zmpp_pkg::t_cfg c);
        write_reg(zmpp_pkg::CFG_FILTER_ENABLED, 64'(c.filter_enabled));
        write_reg(zmpp_pkg::CFG_COLUMN_TYPE, 64'(c.column_type));
        write_reg(zmpp_pkg::CFG_LOW_ENABLED, 64'(c.low_enabled));
        write_reg(zmpp_pkg::CFG_HIGH_ENABLED, 64'(c.high_enabled));
        write_reg(zmpp_pkg::CFG_LOW_BOUND, c.low_bound);
        write_reg(zmpp_pkg::CFG_HIGH_BOUND, c.high_bound);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_page(zmpp_pkg::t_page_req p, bit has_exp,
                             zmpp_pkg::t_range_req exp_r);
        zmpp_pkg::t_range_req r;
        bit                   found;
        bit                   idle;
        idle = $urandom_range(99) < send_idle_pct;
        while (idle) begin
            page_valid <= 1'b0;
            @(negedge clk);
            idle = $urandom_range(99) < send_idle_pct;
        end
        found = predict_range(p, r);
        if (has_exp && (!found || r != exp_r)) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row disagrees with predictor: table %h got %h", exp_r, r);
        end
        if (found) range_queue.insert(range_queue.size(), r);
        page <= p;
        page_valid <= 1'b1;
        do @(posedge clk); while (page_stall);
        pages_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        page_valid <= 1'b0;
        while (range_queue.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_value(int col, logic [63:0] center);
        logic [63:0] v;
        case ($urandom_range(9))
            0: v = rand64();
            1: v = 64'h7ff8_0000_0000_0001;
            2: v = 64'hffff_ffff_ffff_ffff;
            3: v = 64'h8000_0000_0000_0000;
            default: begin
                if (col == zmpp_pkg::COL_DOUBLE)
                    v = $realtobits($bitstoreal(center) + ($urandom_range(200) - 100.0));
                else
                    v = center + 64'($signed($urandom_range(200)) - 100);
            end
        endcase
        return v;
    endfunction

    function automatic zmpp_pkg::t_page_req rand_page(int final_pct);
        zmpp_pkg::t_page_req p;
        logic [63:0] a, b, mid;
        mid = cfg_shadow.column_type == zmpp_pkg::COL_DOUBLE ? $realtobits(0.0) : 64'd0;
        a = pick_value(cfg_shadow.column_type, mid);
        b = pick_value(cfg_shadow.column_type, mid);
        case ($urandom_range(9))
            0: p.page_rows = 16'd0;
            1: p.page_rows = 16'hffff;
            default: p.page_rows = 16'($urandom_range(1, 300));
        endcase
        p.stats_present = $urandom_range(9) != 0;
        p.page_min = a;
        p.page_max = b;
        p.final_page = $urandom_range(99) < final_pct;
        return p;
    endfunction

    task automatic load_table();
        t_dir_row row;
        row.has_exp = 1'b1;
        // filtering off after reset: every page survives
        row.page = '{16'd10, 1'b0, 64'd0, 64'd0, 1'b0};
        row.exp_range = '0; row.has_exp = 1'b0; dir_rows.insert(dir_rows.size(), row);
        row.page = '{16'd0, 1'b1, 64'd0, 64'd0, 1'b0}; dir_rows.insert(dir_rows.size(), row);
        row.page = '{16'hffff, 1'b1, '1, '0, 1'b1};
        row.has_exp = 1'b1; row.exp_range = '{40'd0, 40'd65545, 1'b1, 1'b0};
        dir_rows.insert(dir_rows.size(), row);
        row.page = '{16'd0, 1'b0, 64'd0, 64'd0, 1'b1};
        row.exp_range = '{40'd0, 40'd0, 1'b1, 1'b1}; dir_rows.insert(dir_rows.size(), row);
        row.page = '{16'd5, 1'b1, 64'd0, 64'd0, 1'b1};
        row.exp_range = '{40'd0, 40'd5, 1'b1, 1'b0}; dir_rows.insert(dir_rows.size(), row);
    endtask

    task automatic run_segment_set(int count);
        zmpp_pkg::t_page_req  p;
        zmpp_pkg::t_range_req none;
        none = '0;
        for (int i = 0; i < count; i++) begin
            p = rand_page(8);
            send_page(p, 1'b0, none);
        end
    endtask

    task automatic directed_filter(logic [1:0] col, logic [63:0] lb, logic [63:0] hb);
        zmpp_pkg::t_cfg       c;
        zmpp_pkg::t_page_req  p;
        zmpp_pkg::t_range_req none;
        none = '0;
        c = '{1'b1, col, 1'b1, 1'b1, lb, hb};
        write_all(c);
        p = '{16'd4, 1'b1, lb, hb, 1'b0};                    send_page(p, 1'b0, none);
        p = '{16'd4, 1'b0, lb, hb, 1'b0};                    send_page(p, 1'b0, none);
        p = '{16'd3, 1'b1, 64'h7ff8_0000_0000_0000, hb, 1'b0}; send_page(p, 1'b0, none);
        p = '{16'd3, 1'b1, hb + 1, hb + 2, 1'b0};            send_page(p, 1'b0, none);
        p = '{16'd0, 1'b0, '0, '0, 1'b0};                    send_page(p, 1'b0, none);
        p = '{16'd2, 1'b1, lb - 2, lb - 1, 1'b1};            send_page(p, 1'b0, none);
        drain();
    endtask

    // hold the receiver stall at the chosen rate
    always @(negedge clk) begin
        if (!rst_n) range_stall <= 1'b0;
        else        range_stall <= $urandom_range(99) < recv_stall_pct;
    end

    always @(posedge clk) begin
        if (rst_n && range_valid && !range_stall) begin
            ranges_seen++;
            if (range_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected range request %h", range_out);
            end else begin
                if (range_out.span_first != range_queue[0].span_first ||
                    range_out.span_after != range_queue[0].span_after ||
                    range_out.last_range != range_queue[0].last_range ||
                    range_out.no_range != range_queue[0].no_range) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("range mismatch: expected %h actual %h",
                                 range_queue[0], range_out);
                end
                void'(range_queue.pop_front());
            end
        end
    end

    // advance the watchdog on cycles with no request accepted
    always @(posedge clk) begin
        if ((page_valid && !page_stall) || (range_valid && !range_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        zmpp_pkg::t_cfg       c;
        zmpp_pkg::t_page_req  p;
        zmpp_pkg::t_range_req none;
        int phase_pct[4][2];
        none = '0;
        phase_pct = '{'{0, 0}, '{61, 0}, '{0, 61}, '{6, 6}};
        rst_n = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        page_valid = 1'b0; page = '0;
        range_stall = 1'b0;
        mismatches = 0; ranges_seen = 0; pages_sent = 0; idle_cycles = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        cfg_shadow = '0; cursor = '0; run_open = 1'b0; run_start = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        load_table();
        foreach (dir_rows[i]) send_page(dir_rows[i].page, dir_rows[i].has_exp,
                                        dir_rows[i].exp_range);
        drain();
        directed_filter(zmpp_pkg::COL_INT32, 64'hffff_ffff_8000_0000 | 64'd100,
                        64'h7fff_ffff);
        directed_filter(zmpp_pkg::COL_INT64, 64'h8000_0000_0000_0000, 64'd50);
        directed_filter(zmpp_pkg::COL_DOUBLE, $realtobits(-1.5), $realtobits(2.5));
        directed_filter(zmpp_pkg::COL_OTHER, '1, '0);

        // run a segment of full-size pages
        c = '{1'b0, zmpp_pkg::COL_INT32, 1'b0, 1'b0, 64'd0, 64'd0};
        write_all(c);
        for (int i = 0; i < 3; i++) begin
            p = '{16'hffff, 1'b1, '0, '0, 1'b0}; send_page(p, 1'b0, none);
        end
        p = '{16'd1, 1'b1, '0, '0, 1'b1}; send_page(p, 1'b0, none);
        drain();

        for (int ph = 0; ph < 16; ph++) begin
            send_idle_pct  = phase_pct[ph % 4][0];
            recv_stall_pct = phase_pct[ph % 4][1];
            c.filter_enabled = $urandom_range(5) != 0;
            c.column_type    = 2'($urandom_range(3));
            c.low_enabled    = $urandom_range(1);
            c.high_enabled   = $urandom_range(1);
            if (c.column_type == zmpp_pkg::COL_DOUBLE) begin
                c.low_bound  = $realtobits(-($urandom_range(60) * 1.0));
                c.high_bound = $realtobits($urandom_range(60) * 1.0);
            end else begin
                c.low_bound  = -64'($urandom_range(60));
                c.high_bound = 64'($urandom_range(60));
            end
            if (ph % 5 == 4) begin
                c.low_bound  = rand64();
                c.high_bound = rand64();
            end
            write_all(c);
            run_segment_set(31);
            p = rand_page(100);
            send_page(p, 1'b0, none);
            drain();
        end

        $display("pages sent %0d, range requests checked %0d, mismatches %0d",
                 pages_sent, ranges_seen, mismatches);
        $display("covered all column types, bound extremes, NaN, empty and full-size pages");
        if (mismatches == 0 && range_queue.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
